// ===== sv/isa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_pkg
// Shared widths, codes and record types of the idle slot allocator.
// ----------------------------------------------------------------------------
package isa_pkg;

    localparam int SLOT_W    = 6;
    localparam int USER_W    = 7;
    localparam int STAMP_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam int DEF_SLOT_COUNT = 64;

    localparam logic [STAMP_W-1:0] MIN_IDLE_RST   = 32'd10000;
    localparam logic [SLOT_W-1:0]  SCAN_START_RST = '0;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_ALLOC  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_IDLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_START = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [SLOT_W-1:0]  slot;
        logic               in_use;
        logic               allocated;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] now;
    } isa_item_t;

    typedef struct packed {
        logic [STAMP_W-1:0] min_idle_time;
        logic [SLOT_W-1:0]  scan_start;
    } isa_cfg_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] chosen_slot;
        logic [USER_W-1:0] user_count;
    } isa_res_t;

    typedef struct packed {
        logic               in_use;
        logic               allocated;
        logic [STAMP_W-1:0] stamp;
    } isa_row_t;

    localparam int ROW_W = $bits(isa_row_t);

endpackage

// ===== sv/isa_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_slot_ram
// Slot record memory, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module isa_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 34
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/isa_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_engine
// Sequencer of the allocator: clearing pass, record update by read-modify-
// write, and a streamed scan over the slot memory that tracks the oldest idle
// candidate, the round-robin free slot and the first free slot.
// ----------------------------------------------------------------------------
module isa_engine import isa_pkg::*; #(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  isa_cfg_t         cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  isa_item_t        in_item,
    output logic             res_valid,
    input  logic             res_ready,
    output isa_res_t         res,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output logic [ROW_W-1:0] wr_data,
    output logic [IDX_W-1:0] rd_addr,
    input  logic [ROW_W-1:0] rd_data
);

    localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CMP_W-1:0] COUNT_C  = CMP_W'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_UPD_RD, S_UPD_WR, S_SCAN, S_DRAIN, S_DONE
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   cnt_reg;
    isa_item_t          item_reg;
    logic [USER_W-1:0]  count_reg;

    logic               d_vld_reg;
    logic               d_last_reg;
    logic [IDX_W-1:0]   d_idx_reg;

    logic               a_vld_reg;
    logic               a_last_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic               a_cand_reg;
    logic               a_free_reg;
    logic [STAMP_W-1:0] a_age_reg;

    logic               have_reg;
    logic [STAMP_W-1:0] best_age_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               rr_hit_reg;
    logic [IDX_W-1:0]   rr_idx_reg;
    logic               any_reg;
    logic [IDX_W-1:0]   first_idx_reg;

    isa_row_t           rd_row;
    isa_row_t           new_row;
    logic [IDX_W-1:0]   upd_addr;
    logic               slot_ok;
    logic [CMP_W-1:0]   scan_w;
    logic [CMP_W-1:0]   start_c;
    logic               cnt_last;
    logic               best_hit;
    logic               first_hit;
    logic               rr_take;
    logic               accept;

    assign rd_row   = isa_row_t'(rd_data);
    assign upd_addr = IDX_W'(item_reg.slot);
    assign slot_ok  = CMP_W'(in_item.slot) < COUNT_C;
    assign scan_w   = CMP_W'(cfg.scan_start);
    assign start_c  = (scan_w < COUNT_C) ? scan_w : '0;
    assign cnt_last = (cnt_reg == LAST_IDX);

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_DONE);

    assign best_hit  = a_cand_reg && (a_age_reg > cfg.min_idle_time)
                       && (!have_reg || (a_age_reg > best_age_reg));
    assign first_hit = a_free_reg && !any_reg;
    assign rr_take   = a_free_reg && !rr_hit_reg && (CMP_W'(a_idx_reg) >= start_c);

    assign new_row.in_use    = item_reg.in_use;
    assign new_row.allocated = item_reg.allocated;
    assign new_row.stamp     = item_reg.stamp;

    // memory ports
    always_comb begin
        wr_en   = (state_reg == S_CLEAR) || (state_reg == S_UPD_WR);
        wr_addr = (state_reg == S_CLEAR) ? cnt_reg : upd_addr;
        wr_data = (state_reg == S_CLEAR) ? '0 : ROW_W'(new_row);
        rd_addr = (state_reg == S_SCAN) ? cnt_reg : upd_addr;
    end

    // result selection
    always_comb begin
        res.found       = 1'b0;
        res.chosen_slot = '0;
        res.user_count  = count_reg;
        if (item_reg.req_type == REQ_ALLOC) begin
            if (have_reg) begin
                res.found       = 1'b1;
                res.chosen_slot = SLOT_W'(best_idx_reg);
            end else if (rr_hit_reg) begin
                res.found       = 1'b1;
                res.chosen_slot = SLOT_W'(rr_idx_reg);
            end else if (any_reg) begin
                res.found       = 1'b1;
                res.chosen_slot = SLOT_W'(first_idx_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            count_reg  <= '0;
            d_vld_reg  <= 1'b0;
            a_vld_reg  <= 1'b0;
            have_reg   <= 1'b0;
            rr_hit_reg <= 1'b0;
            any_reg    <= 1'b0;
        end else begin
            d_vld_reg <= (state_reg == S_SCAN);
            a_vld_reg <= d_vld_reg;
            case (state_reg)
                S_CLEAR: begin
                    cnt_reg <= cnt_last ? '0 : cnt_reg + 1'b1;
                    if (cnt_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_valid) begin
                        cnt_reg <= '0;
                        if (in_item.req_type == REQ_ALLOC) begin
                            state_reg <= S_SCAN;
                        end else if (slot_ok) begin
                            state_reg <= S_UPD_RD;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_UPD_RD: begin
                    state_reg <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    if (rd_row.in_use && !item_reg.in_use) begin
                        count_reg <= count_reg - 1'b1;
                    end else if (!rd_row.in_use && item_reg.in_use) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_SCAN: begin
                    cnt_reg <= cnt_last ? '0 : cnt_reg + 1'b1;
                    if (cnt_last) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (a_vld_reg && a_last_reg) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (accept) begin
                have_reg   <= 1'b0;
                rr_hit_reg <= 1'b0;
                any_reg    <= 1'b0;
            end else if (a_vld_reg) begin
                if (best_hit) begin
                    have_reg <= 1'b1;
                end
                if (rr_take) begin
                    rr_hit_reg <= 1'b1;
                end
                if (first_hit) begin
                    any_reg <= 1'b1;
                end
            end
        end
    end

    // scan datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
        d_last_reg <= cnt_last;
        d_idx_reg  <= cnt_reg;
        a_last_reg <= d_last_reg;
        a_idx_reg  <= d_idx_reg;
        a_cand_reg <= !rd_row.in_use && rd_row.allocated;
        a_free_reg <= !rd_row.in_use;
        a_age_reg  <= item_reg.now - rd_row.stamp;
        if (a_vld_reg) begin
            if (best_hit) begin
                best_age_reg <= a_age_reg;
                best_idx_reg <= a_idx_reg;
            end
            if (rr_take) begin
                rr_idx_reg <= a_idx_reg;
            end
            if (first_hit) begin
                first_idx_reg <= a_idx_reg;
            end
        end
    end

endmodule

// ===== sv/idle_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_slot_allocator
// Session slot table with idle-age based slot allocation.
//
// Items arrive on the s_ channel (valid/ready). An update beat rewrites one
// slot record; a request beat picks a slot: the free-but-allocated slot with
// the largest idle age above min_idle_time, else the first free slot found
// round-robin from scan_start. Every beat yields one m_ beat that also
// carries the count of in-use slots. The user must write registers on the cfg_ port
// only while the block is idle; the block itself does not enforce it.
// A request streams every slot record through the single memory read port
// once, one slot a cycle. One item is in work at a time.
// After reset a clearing pass over every slot zeroes the marks; s_ready
// stays low until it ends. Configuration reverts to its reset values.
// Results sit in an output register: the next beat is accepted while a result
// waits, and a stalled m_ready holds only the finish of that next item.
// ----------------------------------------------------------------------------
module idle_slot_allocator import isa_pkg::*; #(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [SLOT_W-1:0]    s_slot,
    input  logic                 s_in_use,
    input  logic                 s_allocated,
    input  logic [STAMP_W-1:0]   s_stamp,
    input  logic [STAMP_W-1:0]   s_now,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_found,
    output logic [SLOT_W-1:0]    m_chosen_slot,
    output logic [USER_W-1:0]    m_user_count,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    isa_cfg_t         cfg_reg;
    isa_item_t        in_item;
    isa_res_t         res;
    isa_res_t         res_reg;
    logic             m_valid_reg;
    logic             res_valid;
    logic             res_ready;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ROW_W-1:0] rd_data;

    assign in_item.req_type  = s_req_type;
    assign in_item.slot      = s_slot;
    assign in_item.in_use    = s_in_use;
    assign in_item.allocated = s_allocated;
    assign in_item.stamp     = s_stamp;
    assign in_item.now       = s_now;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_idle_time <= MIN_IDLE_RST;
            cfg_reg.scan_start    <= SCAN_START_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_IDLE:   cfg_reg.min_idle_time <= cfg_wdata;
                REG_SCAN_START: cfg_reg.scan_start    <= cfg_wdata[SLOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    isa_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W),
        .DW    (ROW_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    isa_engine #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = res_reg.found;
    assign m_chosen_slot = res_reg.chosen_slot;
    assign m_user_count  = res_reg.user_count;

`ifndef ASSERT_OFF
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in work");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (SLOT_COUNT >= 128) || (32'(m_user_count) <= SLOT_COUNT))
        else $error("in-use count above slot count");

    a_chosen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> (32'(m_chosen_slot) < SLOT_COUNT) || (SLOT_COUNT > 64))
        else $error("chosen slot outside the table");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_chosen_slot == '0))
        else $error("slot index given without a find");
`endif

endmodule
